// File: sv/vqdm_pkg.sv
`timescale 1ns / 1ps

package vqdm_pkg;

    localparam int DESC_COUNT = 256;
    localparam int ID_W       = 8;
    localparam int QSZ_W      = 9;
    localparam int IDX_W      = 16;
    localparam int LEN_W      = 32;
    localparam int ADDR_W     = 64;
    localparam int MOD_CNT_W  = $clog2(ID_W);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_KICK     = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic REG_QUEUE_SIZE = 1'b0;

    typedef logic [ID_W-1:0] t_desc_id;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] buffer_address;
        logic [LEN_W-1:0]  buffer_length;
        logic              device_writes;
        logic [IDX_W-1:0]  device_used_index;
        t_desc_id          completed_id;
        logic [LEN_W-1:0]  completed_length;
    } t_vq_req;

    typedef struct packed {
        logic [1:0]       status;
        t_desc_id         descriptor_id;
        t_desc_id         ring_slot;
        logic [IDX_W-1:0] avail_count;
        logic [LEN_W-1:0] returned_length;
        logic [IDX_W-1:0] notify_value;
        logic [QSZ_W-1:0] free_descriptors;
    } t_vq_rsp;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0]       in_op;
        logic             mod_last;
        logic             out_busy;
        logic [QSZ_W-1:0] free_count;
        logic [QSZ_W-1:0] eff_size;
        logic [QSZ_W-1:0] queue_size;
    } t_dp_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_COMMIT
    } t_state;

    function automatic logic [QSZ_W-1:0] eff_size(input logic [QSZ_W-1:0] q);
        logic [QSZ_W-1:0] n;
        n = q;
        if (q == '0) begin
            n = QSZ_W'(1);
        end else if (q > QSZ_W'(DESC_COUNT)) begin
            n = QSZ_W'(DESC_COUNT);
        end
        return n;
    endfunction

endpackage

// File: sv/vqdm_ctrl.sv
`timescale 1ns / 1ps

module vqdm_ctrl
    import vqdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output logic       o_in_ready,
    output t_ctl_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_st.in_op == OP_COMPLETE) ? S_MOD : S_COMMIT;
                end
            end
            S_MOD: begin
                if (i_st.mod_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!i_st.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.mod_step = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = !i_st.out_busy;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: sv/vqdm_datapath.sv
`timescale 1ns / 1ps

module vqdm_datapath
    import vqdm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_vq_req                i_in,
    input  t_ctl_cmd               i_cmd,
    input  logic                   i_cfg_wr,
    input  logic [QSZ_W-1:0]       i_cfg_size,
    input  logic                   i_out_ready,
    output t_dp_status             o_st,
    output logic                   o_out_valid,
    output t_vq_rsp                o_out
);

    logic [ID_W-1:0]       r_link_mem [DESC_COUNT];
    logic [DESC_COUNT-1:0] r_link_vld;
    t_desc_id              r_rd_link;
    logic                  r_rd_vld;

    logic [QSZ_W-1:0]     r_qsize;
    t_desc_id             r_free_head;
    logic [QSZ_W-1:0]     r_free_count;
    logic [IDX_W-1:0]     r_avail;
    t_desc_id             r_slot;
    logic [IDX_W-1:0]     r_last_used;
    t_vq_req              r_item;

    t_desc_id             r_div;
    t_desc_id             r_rem;
    logic [MOD_CNT_W-1:0] r_cnt;

    logic                 r_out_valid;
    t_vq_rsp              r_out;

    logic [QSZ_W-1:0] w_n;
    logic [QSZ_W-1:0] w_trial;
    logic [QSZ_W-1:0] w_head_inc;
    t_desc_id         w_dflt_link;
    logic [QSZ_W-1:0] w_slot_inc;

    t_vq_rsp          n_out;
    t_desc_id         n_free_head;
    logic [QSZ_W-1:0] n_free_count;
    logic [IDX_W-1:0] n_avail;
    t_desc_id         n_slot;
    logic [IDX_W-1:0] n_last_used;
    logic             w_wr_en;
    t_desc_id         w_wr_addr;
    t_desc_id         w_wr_data;

    assign w_n         = eff_size(r_qsize);
    assign w_trial     = {r_rem, r_div[ID_W-1]};
    assign w_head_inc  = {1'b0, r_free_head} + QSZ_W'(1);
    assign w_dflt_link = (w_head_inc < w_n) ? w_head_inc[ID_W-1:0] : '0;
    assign w_slot_inc  = {1'b0, r_slot} + QSZ_W'(1);

    assign o_st.in_op      = i_in.operation;
    assign o_st.mod_last   = (r_cnt == '0);
    assign o_st.out_busy   = r_out_valid && !i_out_ready;
    assign o_st.free_count = r_free_count;
    assign o_st.eff_size   = w_n;
    assign o_st.queue_size = r_qsize;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_out        = '0;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_avail      = r_avail;
        n_slot       = r_slot;
        n_last_used  = r_last_used;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_free_head;
        w_wr_data    = '0;
        unique case (r_item.operation)
            OP_ADD: begin
                if (r_free_count == '0) begin
                    n_out.status = ST_NOFREE;
                end else begin
                    n_out.descriptor_id = r_free_head;
                    n_out.ring_slot     = r_slot;
                    n_free_head         = r_rd_vld ? r_rd_link : w_dflt_link;
                    n_free_count        = r_free_count - QSZ_W'(1);
                    n_avail             = r_avail + IDX_W'(1);
                    if (r_avail == '1 || w_slot_inc == w_n) begin
                        n_slot = '0;
                    end else begin
                        n_slot = w_slot_inc[ID_W-1:0];
                    end
                    w_wr_en = 1'b1;
                end
            end
            OP_COMPLETE: begin
                if (r_item.device_used_index == r_last_used) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.descriptor_id   = r_rem;
                    n_out.returned_length = r_item.completed_length;
                    n_free_head           = r_rem;
                    if (r_free_count < w_n) begin
                        n_free_count = r_free_count + QSZ_W'(1);
                    end
                    n_last_used = r_last_used + IDX_W'(1);
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_rem;
                    w_wr_data   = r_free_head;
                end
            end
            OP_KICK: begin
                n_out.notify_value = r_avail - IDX_W'(1);
            end
            default: n_out.status = ST_OK;
        endcase
        n_out.avail_count      = n_avail;
        n_out.free_descriptors = n_free_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_link <= r_link_mem[r_free_head];
        end
        if (i_cmd.commit && w_wr_en) begin
            r_link_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in;
            r_rd_vld <= r_link_vld[r_free_head];
            r_div    <= i_in.completed_id;
            r_rem    <= '0;
        end else if (i_cmd.mod_step) begin
            r_div <= {r_div[ID_W-2:0], 1'b0};
            r_rem <= (w_trial >= w_n) ? ID_W'(w_trial - w_n) : w_trial[ID_W-1:0];
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsize      <= QSZ_W'(DESC_COUNT);
            r_free_head  <= '0;
            r_free_count <= QSZ_W'(DESC_COUNT);
            r_avail      <= '0;
            r_slot       <= '0;
            r_last_used  <= '0;
            r_link_vld   <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= MOD_CNT_W'(ID_W - 1);
            end else if (i_cmd.mod_step) begin
                r_cnt <= r_cnt - MOD_CNT_W'(1);
            end
            if (i_cfg_wr) begin
                r_qsize      <= i_cfg_size;
                r_free_head  <= '0;
                r_free_count <= eff_size(i_cfg_size);
                r_avail      <= '0;
                r_slot       <= '0;
                r_last_used  <= '0;
                r_link_vld   <= '0;
            end else if (i_cmd.commit) begin
                r_free_head  <= n_free_head;
                r_free_count <= n_free_count;
                r_avail      <= n_avail;
                r_slot       <= n_slot;
                r_last_used  <= n_last_used;
                if (w_wr_en) begin
                    r_link_vld[w_wr_addr] <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: sv/virtqueue_descriptor_manager.sv
`timescale 1ns / 1ps

// Driver side of a split virtqueue: free descriptors are chained from a head
// through a 256-entry link memory. One transaction gives exactly one response.
// Add and kick go from accept to commit; an add takes the new free head from
// the registered read of the head descriptor's link memory. For a complete,
// the completed id is first reduced modulo the queue size by an 8-step
// one-bit-per-cycle remainder unit, then committed. A new transaction may be
// accepted while the previous response is still waiting on o_out. Reset and
// queue_size writes take effect at once; no clearing pass is needed.
module virtqueue_descriptor_manager
    import vqdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_vq_req               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_vq_rsp               o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_ctl_cmd   w_cmd;
    t_dp_status w_st;
    logic       w_cfg_wr;
    logic       w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_QUEUE_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_sel;
    assign prdata    = w_reg_sel ? APB_DATA_W'(w_st.queue_size) : '0;

    vqdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    vqdm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_size  (pwdata[QSZ_W-1:0]),
        .i_out_ready (i_out_ready),
        .o_st        (w_st),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.free_count <= w_st.eff_size)
        else $error("free count above queue size");

    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_NOFREE |-> o_out.free_descriptors == '0)
        else $error("no-free status with free descriptors");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("transaction accepted while busy");

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("commit without response");

endmodule
